// File: sv/rle_pkg.sv
// Package for the ring leader election node: message type codes and
// countdown and phase constants. No dependencies.
package rle_pkg;

    localparam logic [1:0] MT_NULL   = 2'd0;
    localparam logic [1:0] MT_SELECT = 2'd1;
    localparam logic [1:0] MT_NOTIFY = 2'd2;

    // exit countdown start value and phase saturation point
    localparam logic [1:0] CD_START  = 2'd2;
    localparam int         PHASE_W   = 5;
    localparam logic [PHASE_W-1:0] PHASE_MAX = 5'd31;

endpackage

// File: sv/rle_if.sv
// Valid/ready channel interfaces of the ring leader election node: one round
// of received messages in, one round of sent messages out. No dependencies.
interface ring_round_if #(
    parameter int UID_BITS = 16,
    parameter int HOP_BITS = 16
);
    logic                valid;
    logic                ready;
    logic [1:0]          pred_type;
    logic [UID_BITS-1:0] pred_uid;
    logic                pred_inbound;
    logic [HOP_BITS-1:0] pred_hops;
    logic [1:0]          succ_type;
    logic [UID_BITS-1:0] succ_uid;
    logic                succ_inbound;
    logic [HOP_BITS-1:0] succ_hops;

    modport source (
        output valid, pred_type, pred_uid, pred_inbound, pred_hops,
               succ_type, succ_uid, succ_inbound, succ_hops,
        input  ready
    );
    modport sink (
        input  valid, pred_type, pred_uid, pred_inbound, pred_hops,
               succ_type, succ_uid, succ_inbound, succ_hops,
        output ready
    );
endinterface

interface ring_result_if #(
    parameter int UID_BITS = 16,
    parameter int HOP_BITS = 16
);
    logic                valid;
    logic                ready;
    logic                to_pred_valid;
    logic [1:0]          to_pred_type;
    logic [UID_BITS-1:0] to_pred_uid;
    logic                to_pred_inbound;
    logic [HOP_BITS-1:0] to_pred_hops;
    logic                to_succ_valid;
    logic [1:0]          to_succ_type;
    logic [UID_BITS-1:0] to_succ_uid;
    logic                to_succ_inbound;
    logic [HOP_BITS-1:0] to_succ_hops;
    logic                is_leader;
    logic                exited;

    modport source (
        output valid, to_pred_valid, to_pred_type, to_pred_uid, to_pred_inbound,
               to_pred_hops, to_succ_valid, to_succ_type, to_succ_uid,
               to_succ_inbound, to_succ_hops, is_leader, exited,
        input  ready
    );
    modport sink (
        input  valid, to_pred_valid, to_pred_type, to_pred_uid, to_pred_inbound,
               to_pred_hops, to_succ_valid, to_succ_type, to_succ_uid,
               to_succ_inbound, to_succ_hops, is_leader, exited,
        output ready
    );
endinterface

// File: sv/ring_leader_election_node.sv
// One node of a bidirectional ring running Hirschberg-Sinclair election.
// Depends on rle_pkg and the channel interfaces in rle_if.sv.
//
// Usage:
//   i_in carries one ring round per transaction: the messages received from
//   the predecessor and from the successor. o_out returns one transaction per
//   round: the messages sent this round (prepared in the previous round and
//   gated by channel state), the leader flag and the exited flag.
//   The APB port holds node_uid at byte address 0; writing it restarts the
//   node with fresh probes carrying the new identifier. Write it only while
//   no round is in flight.
// Pipeline:
//   An accepted round's result is loaded into the output register in the
//   cycle after acceptance; one round per cycle while o_out is not stalled.
//   The round logic is a single compare-and-select pass from the input port
//   into the state and result registers.
// Reset and stall:
//   Reset loads node_uid 0 and the restart state. While o_out is stalled the
//   result register holds one round and i_in.ready drops in the same cycle;
//   a round is still taken when the waiting result leaves in that cycle.
module ring_leader_election_node #(
    parameter int UID_BITS = 16,
    parameter int HOP_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ring_round_if.sink            i_in,
    ring_result_if.source         o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [((UID_BITS > 32) ? 64 : 32)-1:0] pwdata,
    output logic [((UID_BITS > 32) ? 64 : 32)-1:0] prdata,
    output logic                  pready
);

    localparam int DATA_BITS = (UID_BITS > 32) ? 64 : 32;
    localparam int PW        = rle_pkg::PHASE_W;

    typedef struct packed {
        logic [1:0]          mtype;
        logic [UID_BITS-1:0] uid;
        logic                inbound;
        logic [HOP_BITS-1:0] hops;
    } t_msg;

    // state
    logic [UID_BITS-1:0] r_uid;
    t_msg                r_pend_pred, n_pend_pred;
    t_msg                r_pend_succ, n_pend_succ;
    logic [PW-1:0]       r_phase, n_phase;
    logic                r_leader, n_leader;
    logic [1:0]          r_own_cd, n_own_cd;
    logic [1:0]          r_succ_cd, n_succ_cd;
    logic                r_pred_closed, n_pred_closed;

    // result register
    logic                r_out_valid;
    t_msg                r_to_pred, n_to_pred;
    t_msg                r_to_succ, n_to_succ;
    logic                r_to_pred_valid, n_to_pred_valid;
    logic                r_to_succ_valid, n_to_succ_valid;
    logic                r_is_leader, n_is_leader;
    logic                r_exited, n_exited;

    logic    in_acc;
    logic    out_acc;
    logic    cfg_wr;
    logic    pred_open;
    logic    succ_open;
    t_msg    fp, fs;
    t_msg    restart_msg;
    logic [PW-1:0]       ph_next;
    logic [HOP_BITS-1:0] ph_hops;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? DATA_BITS'(r_uid) : '0;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_acc    = o_out.valid && o_out.ready;

    assign pred_open = !r_pred_closed;
    assign succ_open = (r_succ_cd != 2'd0);

    assign restart_msg = '{mtype: rle_pkg::MT_SELECT, uid: UID_BITS'(pwdata),
                           inbound: 1'b0, hops: HOP_BITS'(1)};

    // next phase and its probe distance
    assign ph_next = (r_phase < rle_pkg::PHASE_MAX) ? r_phase + PW'(1) : r_phase;
    assign ph_hops = (int'(ph_next) >= HOP_BITS) ? '1 : (HOP_BITS'(1) << ph_next);

    always_comb begin
        fp = pred_open ? t_msg'{i_in.pred_type, i_in.pred_uid, i_in.pred_inbound,
                                i_in.pred_hops} : '0;
        fs = succ_open ? t_msg'{i_in.succ_type, i_in.succ_uid, i_in.succ_inbound,
                                i_in.succ_hops} : '0;

        n_pend_pred   = r_pend_pred;
        n_pend_succ   = r_pend_succ;
        n_phase       = r_phase;
        n_leader      = r_leader;
        n_own_cd      = r_own_cd;
        n_succ_cd     = r_succ_cd;
        n_pred_closed = r_pred_closed;

        n_to_pred_valid = 1'b0;
        n_to_succ_valid = 1'b0;
        n_to_pred       = '0;
        n_to_succ       = '0;

        if (r_own_cd != 2'd0) begin
            n_to_pred_valid = pred_open;
            n_to_succ_valid = succ_open;
            n_to_pred       = pred_open ? r_pend_pred : '0;
            n_to_succ       = succ_open ? r_pend_succ : '0;

            n_pend_pred = '0;
            n_pend_succ = '0;
            if (n_own_cd == 2'd1) n_own_cd = 2'd0;
            if (n_succ_cd == 2'd1) n_succ_cd = 2'd0;

            // leader notification from predecessor
            if (fp.mtype == rle_pkg::MT_NOTIFY && !fp.inbound) begin
                n_pred_closed = 1'b1;
                if (r_leader) begin
                    n_succ_cd = 2'd0;
                    n_own_cd  = 2'd0;
                end else begin
                    n_pend_succ = fp;
                    if (n_own_cd != 2'd0) n_own_cd = n_own_cd - 2'd1;
                end
            end

            // outbound probe from predecessor
            if (fp.mtype == rle_pkg::MT_SELECT && !fp.inbound) begin
                if (fp.uid > r_uid && fp.hops > HOP_BITS'(1)) begin
                    n_pend_succ = '{rle_pkg::MT_SELECT, fp.uid, 1'b0, fp.hops - HOP_BITS'(1)};
                end else if (fp.uid > r_uid && fp.hops == HOP_BITS'(1)) begin
                    n_pend_pred = '{rle_pkg::MT_SELECT, fp.uid, 1'b1, HOP_BITS'(1)};
                end else if (fp.uid == r_uid) begin
                    n_leader    = 1'b1;
                    n_pend_succ = '{rle_pkg::MT_NOTIFY, r_uid, 1'b0, HOP_BITS'(0)};
                    if (n_succ_cd != 2'd0) n_succ_cd = n_succ_cd - 2'd1;
                end
            end

            // outbound probe from successor
            if (fs.mtype == rle_pkg::MT_SELECT && !fs.inbound) begin
                if (fs.uid > r_uid && fs.hops > HOP_BITS'(1)) begin
                    n_pend_pred = '{rle_pkg::MT_SELECT, fs.uid, 1'b0, fs.hops - HOP_BITS'(1)};
                end else if (fs.uid > r_uid && fs.hops == HOP_BITS'(1)) begin
                    n_pend_succ = '{rle_pkg::MT_SELECT, fs.uid, 1'b1, HOP_BITS'(1)};
                end else if (fs.uid == r_uid) begin
                    n_leader = 1'b1;
                end
            end

            // relay returning probes of other nodes
            if (fp.mtype == rle_pkg::MT_SELECT && fp.uid != r_uid && fp.inbound &&
                fp.hops == HOP_BITS'(1)) begin
                n_pend_succ = fp;
            end
            if (fs.mtype == rle_pkg::MT_SELECT && fs.uid != r_uid && fs.inbound &&
                fs.hops == HOP_BITS'(1)) begin
                n_pend_pred = fs;
            end

            // both own probes back: advance phase
            if (fp.mtype == rle_pkg::MT_SELECT && fp.uid == r_uid && fp.inbound &&
                fp.hops == HOP_BITS'(1) &&
                fs.mtype == rle_pkg::MT_SELECT && fs.uid == r_uid && fs.inbound &&
                fs.hops == HOP_BITS'(1)) begin
                n_phase     = ph_next;
                n_pend_pred = '{rle_pkg::MT_SELECT, r_uid, 1'b0, ph_hops};
                n_pend_succ = '{rle_pkg::MT_SELECT, r_uid, 1'b0, ph_hops};
            end
        end

        n_is_leader = n_leader;
        n_exited    = (n_own_cd == 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uid         <= '0;
            r_pend_pred   <= '{rle_pkg::MT_SELECT, UID_BITS'(0), 1'b0, HOP_BITS'(1)};
            r_pend_succ   <= '{rle_pkg::MT_SELECT, UID_BITS'(0), 1'b0, HOP_BITS'(1)};
            r_phase       <= '0;
            r_leader      <= 1'b0;
            r_own_cd      <= rle_pkg::CD_START;
            r_succ_cd     <= rle_pkg::CD_START;
            r_pred_closed <= 1'b0;
            r_out_valid   <= 1'b0;
        end else if (cfg_wr) begin
            // restart with the new identifier
            r_uid         <= UID_BITS'(pwdata);
            r_pend_pred   <= restart_msg;
            r_pend_succ   <= restart_msg;
            r_phase       <= '0;
            r_leader      <= 1'b0;
            r_own_cd      <= rle_pkg::CD_START;
            r_succ_cd     <= rle_pkg::CD_START;
            r_pred_closed <= 1'b0;
        end else begin
            if (in_acc) begin
                r_pend_pred   <= n_pend_pred;
                r_pend_succ   <= n_pend_succ;
                r_phase       <= n_phase;
                r_leader      <= n_leader;
                r_own_cd      <= n_own_cd;
                r_succ_cd     <= n_succ_cd;
                r_pred_closed <= n_pred_closed;
                r_out_valid   <= 1'b1;
            end else if (out_acc) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    // result payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_to_pred       <= n_to_pred;
            r_to_succ       <= n_to_succ;
            r_to_pred_valid <= n_to_pred_valid;
            r_to_succ_valid <= n_to_succ_valid;
            r_is_leader     <= n_is_leader;
            r_exited        <= n_exited;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.to_pred_valid   = r_to_pred_valid;
    assign o_out.to_pred_type    = r_to_pred.mtype;
    assign o_out.to_pred_uid     = r_to_pred.uid;
    assign o_out.to_pred_inbound = r_to_pred.inbound;
    assign o_out.to_pred_hops    = r_to_pred.hops;
    assign o_out.to_succ_valid   = r_to_succ_valid;
    assign o_out.to_succ_type    = r_to_succ.mtype;
    assign o_out.to_succ_uid     = r_to_succ.uid;
    assign o_out.to_succ_inbound = r_to_succ.inbound;
    assign o_out.to_succ_hops    = r_to_succ.hops;
    assign o_out.is_leader       = r_is_leader;
    assign o_out.exited          = r_exited;

    // a closed predecessor side never sends
    a_pred_closed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_pred_closed && !cfg_wr) |=> (o_out.valid && !o_out.to_pred_valid))
        else $error("message sent on closed predecessor side");

    // once exited, rounds leave the node exited
    a_exit_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_own_cd == 2'd0 && !cfg_wr) |=> (r_own_cd == 2'd0 && o_out.exited))
        else $error("node left exited state without restart");

    // leader flag only clears on restart
    a_leader_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_leader && !cfg_wr) |=> r_leader)
        else $error("leader flag dropped");

    // intake never blocks while the result register is empty
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with empty result register");

endmodule

// File: bench/ring_leader_election_node_tb.sv
`timescale 1ns / 1ps
// Testbench for ring_leader_election_node: random and directed ring rounds with a
// self-checking node predictor and an APB writer for the node id.
// Depends on rle_pkg, the channel interfaces in rle_if.sv and the node RTL.
module ring_leader_election_node_tb;

    localparam int UID_W = 16;
    localparam int HOP_W = 16;
    localparam logic [2:0] REG_NODE_UID = 3'd0;
    localparam logic [1:0] MT_UNUSED = 2'd3;
    localparam int LONG_HOLD = 200;
    localparam int LIMIT_CYCLES = 400_000;
    localparam int ITEM_TARGET = 1900;

    typedef struct packed {
        logic [1:0]       kind;
        logic [UID_W-1:0] uid;
        logic             inbound;
        logic [HOP_W-1:0] hops;
    } ring_msg_t;

    typedef struct packed {
        ring_msg_t from_pred;
        ring_msg_t from_succ;
    } round_t;

    typedef struct packed {
        logic      to_pred_valid;
        ring_msg_t to_pred;
        logic      to_succ_valid;
        ring_msg_t to_succ;
        logic      is_leader;
        logic      exited;
    } sent_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ring_round_if  #(.UID_BITS(UID_W), .HOP_BITS(HOP_W)) rin ();
    ring_result_if #(.UID_BITS(UID_W), .HOP_BITS(HOP_W)) rout ();

    ring_leader_election_node #(.UID_BITS(UID_W), .HOP_BITS(HOP_W)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (rin.sink),
        .o_out   (rout.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // node predictor state
    logic [UID_W-1:0] nd_uid;
    ring_msg_t        nd_to_pred;
    ring_msg_t        nd_to_succ;
    logic [rle_pkg::PHASE_W-1:0] nd_phase;
    logic             nd_leader;
    logic [1:0]       nd_own_cd;
    logic [1:0]       nd_succ_cd;
    logic             nd_pred_closed;

    round_t round_q[$];
    sent_t  sent_q[$];
    round_t cur_round;

    int  items_queued = 0;
    int  rounds_taken = 0;
    int  results_seen = 0;
    int  fail_cnt = 0;
    int  leader_results = 0;
    int  exited_results = 0;
    int  uid_writes = 0;
    int  deepest_phase = 0;
    int  src_gap = 0;
    int  sink_gap = 0;
    int  hold_left = 0;
    int  hold_requests = 0;
    int  hold_served = 0;
    int  cycle_cnt = 0;
    bit  src_calm = 0;
    bit  sink_calm = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void restart_node();
        nd_to_pred     = '{kind: rle_pkg::MT_SELECT, uid: nd_uid, inbound: 1'b0,
                           hops: HOP_W'(1)};
        nd_to_succ     = nd_to_pred;
        nd_phase       = '0;
        nd_leader      = 1'b0;
        nd_own_cd      = rle_pkg::CD_START;
        nd_succ_cd     = rle_pkg::CD_START;
        nd_pred_closed = 1'b0;
    endfunction

    function automatic logic [1:0] dec_sat(logic [1:0] v);
        return (v != 2'd0) ? v - 2'd1 : 2'd0;
    endfunction

    // one ring round: emit what was prepared, then rebuild pending messages
    function automatic sent_t advance_round(round_t r);
        sent_t            s;
        ring_msg_t        fp;
        ring_msg_t        fs;
        logic             pred_open;
        logic             succ_open;
        logic [HOP_W-1:0] new_hops;
        logic [UID_W-1:0] me;

        me        = nd_uid;
        fp        = r.from_pred;
        fs        = r.from_succ;
        pred_open = !nd_pred_closed;
        succ_open = (nd_succ_cd != 2'd0);
        s         = '0;

        if (nd_own_cd == 2'd0) begin
            s.is_leader = nd_leader;
            s.exited    = 1'b1;
            return s;
        end

        s.to_pred_valid = pred_open;
        s.to_pred       = pred_open ? nd_to_pred : '0;
        s.to_succ_valid = succ_open;
        s.to_succ       = succ_open ? nd_to_succ : '0;

        nd_to_pred = '0;
        nd_to_succ = '0;
        if (!pred_open) fp = '0;
        if (!succ_open) fs = '0;
        if (nd_own_cd == 2'd1) nd_own_cd = 2'd0;
        if (nd_succ_cd == 2'd1) nd_succ_cd = 2'd0;

        if (fp.kind == rle_pkg::MT_NOTIFY && !fp.inbound) begin
            nd_pred_closed = 1'b1;
            if (nd_leader) begin
                nd_succ_cd = 2'd0;
                nd_own_cd  = 2'd0;
            end else begin
                nd_to_succ = fp;
                nd_own_cd  = dec_sat(nd_own_cd);
            end
        end

        if (fp.kind == rle_pkg::MT_SELECT && !fp.inbound) begin
            if (fp.uid > me && fp.hops > 1) begin
                nd_to_succ = '{rle_pkg::MT_SELECT, fp.uid, 1'b0, fp.hops - 1'b1};
            end else if (fp.uid > me && fp.hops == 1) begin
                nd_to_pred = '{rle_pkg::MT_SELECT, fp.uid, 1'b1, HOP_W'(1)};
            end else if (fp.uid == me) begin
                nd_leader  = 1'b1;
                nd_to_succ = '{rle_pkg::MT_NOTIFY, me, 1'b0, HOP_W'(0)};
                nd_succ_cd = dec_sat(nd_succ_cd);
            end
        end

        if (fs.kind == rle_pkg::MT_SELECT && !fs.inbound) begin
            if (fs.uid > me && fs.hops > 1) begin
                nd_to_pred = '{rle_pkg::MT_SELECT, fs.uid, 1'b0, fs.hops - 1'b1};
            end else if (fs.uid > me && fs.hops == 1) begin
                nd_to_succ = '{rle_pkg::MT_SELECT, fs.uid, 1'b1, HOP_W'(1)};
            end else if (fs.uid == me) begin
                nd_leader = 1'b1;
            end
        end

        if (fp.kind == rle_pkg::MT_SELECT && fp.uid != me && fp.inbound && fp.hops == 1)
            nd_to_succ = fp;
        if (fs.kind == rle_pkg::MT_SELECT && fs.uid != me && fs.inbound && fs.hops == 1)
            nd_to_pred = fs;

        if (fp.kind == rle_pkg::MT_SELECT && fp.uid == me && fp.inbound && fp.hops == 1 &&
            fs.kind == rle_pkg::MT_SELECT && fs.uid == me && fs.inbound &&
            fs.hops == 1) begin
            if (nd_phase < rle_pkg::PHASE_MAX) nd_phase = nd_phase + 1'b1;
            if (int'(nd_phase) > deepest_phase) deepest_phase = int'(nd_phase);
            new_hops   = (nd_phase >= HOP_W) ? '1 : HOP_W'(1) << nd_phase;
            nd_to_pred = '{rle_pkg::MT_SELECT, me, 1'b0, new_hops};
            nd_to_succ = nd_to_pred;
        end

        s.is_leader = nd_leader;
        s.exited    = (nd_own_cd == 2'd0);
        return s;
    endfunction

    function automatic int draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    // sender: hold the offered round until taken, then wait out a drawn gap
    always @(posedge i_clk) begin : round_drv
        bit took;
        int g;
        if (!i_rst_n) begin
            rin.valid <= 1'b0;
            src_gap   <= 0;
        end else begin
            took = rin.valid && rin.ready;
            if (took) begin
                sent_q.push_back(advance_round(cur_round));
                rounds_taken++;
            end
            if (!rin.valid || took) begin
                g = took ? draw_gap(src_calm) : src_gap;
                if (g > 0) begin
                    rin.valid <= 1'b0;
                    src_gap   <= g - 1;
                end else if (round_q.size() != 0) begin
                    cur_round = round_q.pop_front();
                    rin.pred_type    <= cur_round.from_pred.kind;
                    rin.pred_uid     <= cur_round.from_pred.uid;
                    rin.pred_inbound <= cur_round.from_pred.inbound;
                    rin.pred_hops    <= cur_round.from_pred.hops;
                    rin.succ_type    <= cur_round.from_succ.kind;
                    rin.succ_uid     <= cur_round.from_succ.uid;
                    rin.succ_inbound <= cur_round.from_succ.inbound;
                    rin.succ_hops    <= cur_round.from_succ.hops;
                    rin.valid        <= 1'b1;
                    src_gap          <= 0;
                end else begin
                    rin.valid <= 1'b0;
                end
            end
        end
    end

    task automatic cmp_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    // receiver: check each result transaction, stall at random or on request
    always @(posedge i_clk) begin : result_mon
        bit    took;
        int    nxt;
        sent_t want;
        if (!i_rst_n) begin
            rout.ready <= 1'b0;
            sink_gap   <= 0;
            hold_left  <= 0;
        end else begin
            took = rout.valid && rout.ready;
            if (took) begin
                results_seen++;
                if (rout.is_leader === 1'b1) leader_results++;
                if (rout.exited === 1'b1) exited_results++;
                if (sent_q.size() == 0) begin
                    $error("result transaction with no round outstanding");
                    fail_cnt++;
                end else begin
                    want = sent_q.pop_front();
                    cmp_field("to_pred_valid", want.to_pred_valid, rout.to_pred_valid);
                    cmp_field("to_pred_type", want.to_pred.kind, rout.to_pred_type);
                    cmp_field("to_pred_uid", want.to_pred.uid, rout.to_pred_uid);
                    cmp_field("to_pred_inbound", want.to_pred.inbound, rout.to_pred_inbound);
                    cmp_field("to_pred_hops", want.to_pred.hops, rout.to_pred_hops);
                    cmp_field("to_succ_valid", want.to_succ_valid, rout.to_succ_valid);
                    cmp_field("to_succ_type", want.to_succ.kind, rout.to_succ_type);
                    cmp_field("to_succ_uid", want.to_succ.uid, rout.to_succ_uid);
                    cmp_field("to_succ_inbound", want.to_succ.inbound, rout.to_succ_inbound);
                    cmp_field("to_succ_hops", want.to_succ.hops, rout.to_succ_hops);
                    cmp_field("is_leader", want.is_leader, rout.is_leader);
                    cmp_field("exited", want.exited, rout.exited);
                end
            end
            if (hold_served != hold_requests) begin
                hold_served <= hold_requests;
                hold_left   <= LONG_HOLD;
                rout.ready  <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left  <= hold_left - 1;
                rout.ready <= 1'b0;
            end else begin
                nxt = took ? draw_gap(sink_calm) : sink_gap;
                if (nxt > 0) begin
                    rout.ready <= 1'b0;
                    sink_gap   <= nxt - 1;
                end else begin
                    rout.ready <= 1'b1;
                    sink_gap   <= 0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("ring_leader_election_node_tb: done, errors");
            $finish;
        end
    end

    task automatic push_round(ring_msg_t p, ring_msg_t s);
        round_q.push_back('{from_pred: p, from_succ: s});
        items_queued++;
    endtask

    task automatic wait_drained();
        while (rounds_taken != items_queued || results_seen != rounds_taken)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_uid(logic [UID_W-1:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_NODE_UID;
        pwdata  <= {16'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        nd_uid = v;
        restart_node();
        uid_writes++;
    endtask

    function automatic ring_msg_t rand_msg(logic [UID_W-1:0] me, bit notify_ok);
        ring_msg_t m;
        int        p;
        p = $urandom_range(0, 99);
        if (p < 15)                    m.kind = rle_pkg::MT_NULL;
        else if (p < 19)               m.kind = MT_UNUSED;
        else if (notify_ok && p < 23)  m.kind = rle_pkg::MT_NOTIFY;
        else                           m.kind = rle_pkg::MT_SELECT;
        p = $urandom_range(0, 99);
        if (p < 35)
            m.uid = me;
        else if (p < 60)
            m.uid = (me == '1) ? me : UID_W'(me + $urandom_range(1, 32'hFFFF - me));
        else if (p < 75)
            m.uid = (me == '0) ? me : UID_W'($urandom_range(0, me - 1));
        else
            m.uid = UID_W'($urandom);
        m.inbound = 1'($urandom_range(0, 1));
        p = $urandom_range(0, 99);
        if (p < 40)      m.hops = HOP_W'(1);
        else if (p < 50) m.hops = HOP_W'(0);
        else if (p < 75) m.hops = HOP_W'($urandom_range(2, 5));
        else             m.hops = HOP_W'($urandom);
        return m;
    endfunction

    initial begin : stimulus
        ring_msg_t        none;
        ring_msg_t        own_back;
        logic [UID_W-1:0] me;
        int               phase_no;
        int               len;
        int               p;

        none = '0;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        nd_uid = '0;
        restart_node();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // after reset the node id is 0: own probe from successor, phase step, type 3
        push_round(none, none);
        push_round(none, '{rle_pkg::MT_SELECT, 16'h0000, 1'b0, 16'd1});
        push_round('{rle_pkg::MT_SELECT, 16'h0000, 1'b1, 16'd1},
                   '{rle_pkg::MT_SELECT, 16'h0000, 1'b1, 16'd1});
        push_round('{MT_UNUSED, 16'hFFFF, 1'b1, 16'hFFFF}, '{MT_UNUSED, 16'h0000, 1'b0, 16'd0});
        wait_drained();

        write_uid(16'h4000);
        // relay vs turn-around on the same pending slot: later rule wins
        push_round('{rle_pkg::MT_SELECT, 16'hFFFF, 1'b0, 16'hFFFF},
                   '{rle_pkg::MT_SELECT, 16'h4001, 1'b0, 16'd1});
        push_round('{rle_pkg::MT_SELECT, 16'h5000, 1'b0, 16'd1},
                   '{rle_pkg::MT_SELECT, 16'h5000, 1'b0, 16'd3});
        push_round('{rle_pkg::MT_SELECT, 16'h4001, 1'b0, 16'd0},
                   '{rle_pkg::MT_SELECT, 16'h3FFF, 1'b0, 16'd5});
        push_round('{rle_pkg::MT_SELECT, 16'h1234, 1'b1, 16'd1},
                   '{rle_pkg::MT_SELECT, 16'hFFFF, 1'b1, 16'd1});
        push_round('{rle_pkg::MT_SELECT, 16'h1234, 1'b1, 16'd2},
                   '{rle_pkg::MT_SELECT, 16'h4000, 1'b1, 16'd1});
        push_round('{rle_pkg::MT_NOTIFY, 16'h4000, 1'b1, 16'd0},
                   '{rle_pkg::MT_NOTIFY, 16'h7777, 1'b0, 16'd0});
        push_round('{MT_UNUSED, 16'hFFFF, 1'b1, 16'd1}, '{MT_UNUSED, 16'hFFFF, 1'b1, 16'd1});
        push_round('{rle_pkg::MT_SELECT, 16'h4000, 1'b1, 16'd1},
                   '{rle_pkg::MT_SELECT, 16'h4000, 1'b1, 16'd1});
        push_round('{rle_pkg::MT_SELECT, 16'h4000, 1'b0, 16'd4}, none);
        push_round(none, none);
        push_round('{rle_pkg::MT_NOTIFY, 16'h4000, 1'b0, 16'd0}, none);
        push_round(none, '{rle_pkg::MT_SELECT, 16'hFFFF, 1'b0, 16'd2});
        wait_drained();

        write_uid(16'hFFFF);
        // notify reaches a non-leader: relay it, then exit on the next round
        push_round('{rle_pkg::MT_NOTIFY, 16'hAAAA, 1'b0, 16'd7}, none);
        push_round(none, none);
        push_round(none, '{rle_pkg::MT_SELECT, 16'hFFFF, 1'b0, 16'd1});
        wait_drained();

        write_uid(16'h0000);
        push_round('{rle_pkg::MT_SELECT, 16'h0000, 1'b0, 16'd0}, none);
        wait_drained();

        phase_no = 0;
        while (items_queued < ITEM_TARGET) begin
            p = $urandom_range(0, 7);
            me = (p == 0) ? 16'h0000 : (p == 1) ? 16'hFFFF : 16'($urandom);
            write_uid(me);
            own_back = '{rle_pkg::MT_SELECT, me, 1'b1, 16'd1};
            @(posedge i_clk);
            src_calm  <= ($urandom_range(0, 4) == 0);
            sink_calm <= ($urandom_range(0, 4) == 0);
            if (phase_no == 3) begin
                // receiver stops while the sender streams: fill and stall the node
                src_calm      <= 1'b1;
                hold_requests <= hold_requests + 1;
                for (int k = 0; k < 80; k++)
                    push_round(rand_msg(me, 1'b0), rand_msg(me, 1'b1));
            end else if (phase_no % 12 == 7) begin
                // run the phase counter into saturation
                for (int k = 0; k < 36; k++)
                    push_round(own_back, own_back);
                for (int k = 0; k < 4; k++)
                    push_round(rand_msg(me, 1'b0), rand_msg(me, 1'b1));
            end else begin
                len = $urandom_range(15, 60);
                for (int k = 0; k < len; k++) begin
                    p = $urandom_range(0, 99);
                    if (p < 25)
                        push_round(own_back, own_back);
                    else if (p < 28)
                        push_round('{rle_pkg::MT_SELECT, me, 1'b0, 16'($urandom)},
                                   rand_msg(me, 1'b1));
                    else
                        push_round(rand_msg(me, 1'b0), rand_msg(me, 1'b1));
                end
                if ($urandom_range(0, 9) < 6) begin
                    push_round('{rle_pkg::MT_NOTIFY, 16'($urandom), 1'b0, 16'($urandom)},
                               rand_msg(me, 1'b1));
                    push_round(rand_msg(me, 1'b0), rand_msg(me, 1'b1));
                    push_round(rand_msg(me, 1'b0), rand_msg(me, 1'b1));
                end
            end
            wait_drained();
            phase_no++;
        end

        repeat (5) @(posedge i_clk);
        if (sent_q.size() != 0) begin
            $error("%0d expected results never arrived", sent_q.size());
            fail_cnt++;
        end
        $display("checked %0d rounds across %0d node id writes, deepest phase %0d",
                 results_seen, uid_writes, deepest_phase);
        $display("leader flag seen in %0d results, exited in %0d", leader_results,
                 exited_results);
        if (fail_cnt == 0) begin
            $display("ring_leader_election_node_tb: done, clean");
        end else begin
            $display("ring_leader_election_node_tb: done, errors");
        end
        $finish;
    end

endmodule
